### src/swte_pkg.sv
// ----------------------------------------------------------------------------
// swte_pkg: shared types for the sliding window trend estimator
// Item structs for the input and result channels, operation codes and FSM states.
// ----------------------------------------------------------------------------
package swte_pkg;

  localparam int MEAN_BITS  = 24;
  localparam int SLOPE_BITS = 25;
  localparam int FILL_BITS  = 5;

  typedef enum logic [0:0] {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_BITS-1:0]  mean_value;
    logic [SLOPE_BITS-1:0] trend_slope;
    logic [FILL_BITS-1:0]  fill_level;
    logic                  window_full;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

endpackage

### src/swte_cell.sv
// ----------------------------------------------------------------------------
// swte_cell: one window slot
// Holds one sample. Shifts toward the head on a slide, loads on a write, and
// rotates its value to the neighbor during the accumulation pass.
// ----------------------------------------------------------------------------
module swte_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   shift,
  input  logic [SAMPLE_BITS-1:0] load_data,
  input  logic [SAMPLE_BITS-1:0] neighbor,
  output logic [SAMPLE_BITS-1:0] value
);

  always_ff @(posedge clk) begin
    if (load) begin
      value <= load_data;
    end else if (shift) begin
      value <= neighbor;
    end
  end

endmodule

### src/swte_divider.sv
// ----------------------------------------------------------------------------
// swte_divider: signed restoring divider
// One quotient bit per cycle; quotient truncated toward zero.
// ----------------------------------------------------------------------------
module swte_divider #(
  parameter int NUM_BITS = 48,
  parameter int DEN_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_BITS-1:0] numer,
  input  logic        [DEN_BITS-1:0] denom,
  output logic                       busy,
  output logic signed [NUM_BITS-1:0] quot
);

  localparam int CNT_BITS = $clog2(NUM_BITS + 1);

  logic [NUM_BITS-1:0] q;
  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS-1:0] den;
  logic                neg;
  logic [CNT_BITS-1:0] cnt;
  logic [DEN_BITS:0]   trial;
  logic [DEN_BITS:0]   diff;

  assign trial = {rem[DEN_BITS-1:0], q[NUM_BITS-1]};
  assign diff  = trial - {1'b0, den};
  assign quot  = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_BITS'(NUM_BITS);
      q    <= numer[NUM_BITS-1] ? NUM_BITS'(-numer) : numer;
      neg  <= numer[NUM_BITS-1];
      den  <= denom;
      rem  <= '0;
    end else if (busy) begin
      if (!diff[DEN_BITS]) begin
        rem <= diff;
        q   <= {q[NUM_BITS-2:0], 1'b1};
      end else begin
        rem <= trial;
        q   <= {q[NUM_BITS-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

### src/sliding_window_trend_estimator.sv
// ----------------------------------------------------------------------------
// sliding_window_trend_estimator: windowed mean and least-squares slope
// Keeps the last WINDOW_LENGTH samples in a row of cells and reports the
// mean and the slope in Q.8 after every item.
// ----------------------------------------------------------------------------
// One item at a time. An add item slides the cell row, rotates the row a full
// lap past one multiply-accumulate, then the mean and slope divisions run one
// after the other on one shared bit-serial divider. A clear item resets the
// window and answers with a zero result. Results pass through a staging
// register into the output register, which holds until taken; while it waits
// the next item is accepted and computed, and its result waits in the staging
// register.
module sliding_window_trend_estimator #(
  parameter int WINDOW_LENGTH = 16,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  swte_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output swte_pkg::out_item_t  out_item
);
  import swte_pkg::*;

  localparam int CNT_BITS  = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS + 1;
  localparam int D_BITS    = CNT_BITS + 2;
  localparam int S1_BITS   = SAMPLE_BITS + 2 * CNT_BITS + 2;
  localparam int S2_BITS   = 3 * CNT_BITS + 2;
  localparam int MEAN_NUM  = SUM_BITS + 8;
  localparam int SLOPE_NUM = S1_BITS + 9;
  localparam int NUM_BITS  = (MEAN_NUM > SLOPE_NUM) ? MEAN_NUM : SLOPE_NUM;
  localparam int DEN_BITS  = (S2_BITS > CNT_BITS) ? S2_BITS : CNT_BITS;

  state_t state, state_next;

  logic [SAMPLE_BITS-1:0] cells [WINDOW_LENGTH];
  logic [CNT_BITS-1:0]    count;
  logic                   full;
  logic signed [SUM_BITS-1:0] sum;
  logic signed [S1_BITS-1:0]  s1;
  logic        [S2_BITS-1:0]  s2;
  logic [CNT_BITS-1:0]    step;
  logic signed [D_BITS-1:0] d;
  logic                   div_phase;
  logic signed [NUM_BITS-1:0] mean_q;
  out_item_t              res;

  logic slide, rotate, full_now;
  logic [SAMPLE_BITS-1:0] x;

  logic div_start, div_busy;
  logic signed [NUM_BITS-1:0] div_numer, div_quot;
  logic [DEN_BITS-1:0] div_denom;

  assign full_now = (count == CNT_BITS'(WINDOW_LENGTH));
  assign slide    = (state == ST_SHIFT) && full_now;
  assign rotate   = (state == ST_ACC);

  // Row of cells: cell 0 is the oldest. Rotation moves cell 0 to the tail.
  for (genvar i = 0; i < WINDOW_LENGTH; i++) begin : g_cell
    logic load;
    logic [SAMPLE_BITS-1:0] nb;
    assign nb = (i == WINDOW_LENGTH - 1) ? cells[0]
                                         : cells[(i + 1) % WINDOW_LENGTH];
    assign load = (state == ST_SHIFT) &&
                  (full_now ? (i == WINDOW_LENGTH - 1) : (count == CNT_BITS'(i)));
    swte_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
      .clk       (clk),
      .load      (load),
      .shift     (slide || rotate),
      .load_data (x),
      .neighbor  (nb),
      .value     (cells[i])
    );
  end

  // Rotation: with a partial fill, rotate a full lap so order comes back.
  logic signed [SAMPLE_BITS-1:0] head;
  logic in_use;
  assign head   = $signed(cells[0]);
  assign in_use = (step < count);

  always_comb begin
    d = D_BITS'(2) * $signed({1'b0, step}) - ($signed({1'b0, count}) - D_BITS'(1));
  end

  // Divider operands
  assign div_start = ((state == ST_ACC) && (step == CNT_BITS'(WINDOW_LENGTH - 1))) ||
                     ((state == ST_DIV) && !div_busy && !div_phase);
  always_comb begin
    if (state == ST_ACC) begin
      div_numer = NUM_BITS'(sum) <<< 8;
      div_denom = DEN_BITS'(count);
    end else begin
      div_numer = NUM_BITS'(s1) <<< 9;
      div_denom = DEN_BITS'(s2);
    end
  end

  swte_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .busy  (div_busy),
    .quot  (div_quot)
  );

  function automatic logic [MEAN_BITS-1:0] sat_mean(logic signed [NUM_BITS-1:0] v);
    logic signed [NUM_BITS-1:0] hi, lo;
    hi = NUM_BITS'((64'sd1 <<< (MEAN_BITS - 1)) - 1);
    lo = -hi - 1;
    if (v > hi) return MEAN_BITS'(hi);
    if (v < lo) return MEAN_BITS'(lo);
    return MEAN_BITS'(v);
  endfunction

  function automatic logic [SLOPE_BITS-1:0] sat_slope(logic signed [NUM_BITS-1:0] v);
    logic signed [NUM_BITS-1:0] hi, lo;
    hi = NUM_BITS'((64'sd1 <<< (SLOPE_BITS - 1)) - 1);
    lo = -hi - 1;
    if (v > hi) return SLOPE_BITS'(hi);
    if (v < lo) return SLOPE_BITS'(lo);
    return SLOPE_BITS'(v);
  endfunction

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_item.operation == OP_CLEAR) ? ST_OUT : ST_SHIFT;
        end
      end
      ST_SHIFT: state_next = ST_ACC;
      ST_ACC: begin
        if (step == CNT_BITS'(WINDOW_LENGTH - 1)) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_phase && !div_busy) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the control
  always_comb begin
    in_stall = (state != ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      full        <= 1'b0;
      sum         <= '0;
      out_valid   <= 1'b0;
      div_phase   <= 1'b0;
      step        <= '0;
    end else begin
      state <= state_next;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) x <= in_item.sample[SAMPLE_BITS-1:0];
          if (in_valid && in_item.operation == OP_CLEAR) begin
            count <= '0;
            full  <= 1'b0;
            sum   <= '0;
            res   <= '0;
          end
        end
        ST_SHIFT: begin
          if (full_now) begin
            sum <= sum - SUM_BITS'(head) + SUM_BITS'($signed(x));
          end else begin
            sum   <= sum + SUM_BITS'($signed(x));
            count <= count + 1'b1;
            if (count == CNT_BITS'(WINDOW_LENGTH - 1)) full <= 1'b1;
          end
          step <= '0;
          s1   <= '0;
          s2   <= '0;
        end
        ST_ACC: begin
          if (in_use) begin
            s1 <= s1 + S1_BITS'(d * head);
            s2 <= s2 + S2_BITS'(d * d);
          end
          step      <= step + 1'b1;
          div_phase <= 1'b0;
        end
        ST_DIV: begin
          // phase 0: mean done, slope starts; phase 1: slope done
          if (!div_busy) begin
            if (!div_phase) begin
              mean_q    <= div_quot;
              div_phase <= 1'b1;
            end else begin
              res.mean_value  <= sat_mean(mean_q);
              res.trend_slope <= (s2 == '0) ? '0 : sat_slope(div_quot);
              res.fill_level  <= FILL_BITS'(count);
              res.window_full <= full;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            out_item  <= res;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for sliding_window_trend_estimator
// Drives add and clear items through a directed table, then random ones.
// Each result is checked against an in-bench windowed mean/slope predictor or a typed table value.
// ----------------------------------------------------------------------------
module tb;
  import swte_pkg::*;

  localparam int WLEN       = 16;
  localparam int N_RANDOM   = 1250;
  localparam int N_DIRECTED = 24;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_item;

  sliding_window_trend_estimator i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic signed [15:0] win_q [WLEN];
  int                 win_cnt;
  logic               win_full;
  out_item_t          trend_q [$];
  int                 mismatches;
  bit                 idle_en;
  bit                 hold_req;

  typedef struct {
    op_t         op;
    logic [15:0] smp;
    bit          fixed;
    out_item_t   res;
  } stim_row_t;

  function automatic out_item_t predict_trend(in_item_t it);
    out_item_t   r;
    longint      sum;
    longint      s1;
    longint      s2;
    longint      d;
    longint      mean;
    longint      slope;
    r = '0;
    if (it.operation == OP_CLEAR) begin
      win_cnt  = 0;
      win_full = 1'b0;
      return r;
    end
    if (win_cnt >= WLEN) begin
      for (int i = 0; i < WLEN - 1; i++) win_q[i] = win_q[i+1];
      win_q[WLEN-1] = it.sample;
    end else begin
      win_q[win_cnt] = it.sample;
      win_cnt++;
    end
    if (win_cnt == WLEN) win_full = 1'b1;
    sum = 0; s1 = 0; s2 = 0;
    for (int i = 0; i < win_cnt; i++) begin
      d = 2 * i - (win_cnt - 1);
      sum += longint'(win_q[i]);
      s1  += d * longint'(win_q[i]);
      s2  += d * d;
    end
    mean  = (sum * 256) / win_cnt;
    slope = (s2 > 0) ? (s1 * 512) / s2 : 0;
    r.mean_value  = mean[MEAN_BITS-1:0];
    r.trend_slope = slope[SLOPE_BITS-1:0];
    r.fill_level  = win_cnt[FILL_BITS-1:0];
    r.window_full = win_full;
    return r;
  endfunction

  // Queue a prediction; a table row may override it with its typed value.
  function automatic void note_item(in_item_t it, bit fixed, out_item_t res);
    out_item_t p;
    p = predict_trend(it);
    trend_q.push_back(fixed ? res : p);
  endfunction

  task automatic send_item(in_item_t it, bit fixed, out_item_t res);
    int gap;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    note_item(it, fixed, res);
  endtask

  task automatic random_item();
    in_item_t it;
    int       k;
    it.operation = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_ADD;
    k = $urandom_range(0, 9);
    if (k == 0)      it.sample = 16'h7fff;
    else if (k == 1) it.sample = 16'h8000;
    else if (k < 5)  it.sample = 16'($urandom_range(0, 400)) - 16'd200;
    else             it.sample = 16'($urandom);
    send_item(it, 1'b0, '0);
  endtask

  // receiver: random stall bursts plus one long hold
  initial begin : rx_stall
    int n;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (n = 0; n < 600; n++) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && !out_stall) begin
      if (trend_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_item);
      end else begin
        e = trend_q.pop_front();
        if (e.mean_value !== out_item.mean_value ||
            e.trend_slope !== out_item.trend_slope ||
            e.fill_level !== out_item.fill_level ||
            e.window_full !== out_item.window_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result differs: exp mean %h slope %h fill %0d full %0d, got %h %h %0d %0d",
                     e.mean_value, e.trend_slope, e.fill_level, e.window_full,
                     out_item.mean_value, out_item.trend_slope,
                     out_item.fill_level, out_item.window_full);
        end
      end
    end
  end

  initial begin : limit
    #6000000;
    $display("sliding_window_trend_estimator: mismatch");
    $finish;
  end

  initial begin : stimulus
    stim_row_t dir_tbl [N_DIRECTED];
    in_item_t  it;
    out_item_t zero_res;
    out_item_t one_res;
    int        wait_n;
    mismatches = 0;
    idle_en = 1'b0;
    hold_req = 1'b0;
    win_cnt = 0;
    win_full = 1'b0;
    zero_res = '0;
    one_res = '0;
    one_res.mean_value = 24'(32767 * 256);
    one_res.fill_level = 5'd1;
    // clear right after reset, single max sample, clear, single min sample
    dir_tbl[0] = '{OP_CLEAR, 16'h1234, 1'b1, zero_res};
    dir_tbl[1] = '{OP_ADD, 16'h7fff, 1'b1, one_res};
    dir_tbl[2] = '{OP_CLEAR, 16'hffff, 1'b1, zero_res};
    one_res.mean_value = 24'(-32768 * 256);
    dir_tbl[3] = '{OP_ADD, 16'h8000, 1'b1, one_res};
    // alternating extremes to fill and slide the window
    for (int i = 4; i < N_DIRECTED - 1; i++)
      dir_tbl[i] = '{OP_ADD, (i % 2) ? 16'h7fff : 16'h8000, 1'b0, zero_res};
    dir_tbl[N_DIRECTED-1] = '{OP_CLEAR, 16'h0000, 1'b1, zero_res};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      it.operation = dir_tbl[i].op;
      it.sample    = dir_tbl[i].smp;
      send_item(it, dir_tbl[i].fixed, dir_tbl[i].res);
    end

    idle_en = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 200) hold_req = 1'b1;
      if (i == N_RANDOM - 150) idle_en = 1'b0;
      random_item();
    end
    in_valid <= 1'b0;

    wait_n = 0;
    while (trend_q.size() != 0 && wait_n < 100000) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && trend_q.size() == 0) begin
      $display("sliding_window_trend_estimator: match");
    end else begin
      $display("sliding_window_trend_estimator: mismatch");
    end
    $finish;
  end

endmodule
